// File: rtl/wcmm_pkg.sv
// Package for the waveform column min/max unit.
// Holds widths, scaling constants and the controller/datapath interface types.
// No dependencies.
`default_nettype none

package wcmm_pkg;

    // Sample counter and column widths
    localparam int SAMPLE_COUNT_BITS = 24;
    localparam int MAX_COLUMNS       = 4096;
    localparam int COL_W             = $clog2(MAX_COLUMNS + 1);
    localparam int IDX_W             = 12;
    localparam int SAMPLE_W          = 16;
    localparam int HEIGHT_W          = 12;
    localparam int Y_W               = 16;
    localparam int CFG_DATA_W        = 24;
    localparam int CFG_INDEX_W       = 2;

    // Register indexes of the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_TOTAL_SAMPLES = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_COLUMN_COUNT  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW_HEIGHT    = 2'd2;

    // Line end scaling: y = floor((h * (40960 - v) + 2560) / 5120)
    localparam int DIFF_W   = 17;
    localparam int PROD_W   = DIFF_W + HEIGHT_W;
    localparam int Q_W      = PROD_W - 10;
    localparam int RECIP_W  = 20;
    localparam int RECIP_SH = 22;
    localparam int EST_W    = Q_W + RECIP_W;
    localparam int QUOT_W   = EST_W - RECIP_SH;
    localparam logic signed [DIFF_W:0] CENTER_OFFSET = 18'sd40960;
    localparam logic [PROD_W-1:0]      ROUND_HALF    = 29'd2560;
    // floor(2^22 / 5); the estimate falls short by at most one
    localparam logic [RECIP_W-1:0]     RECIP_FIVE    = 20'd838860;
    localparam logic [Q_W-1:0]         DIVISOR_FIVE  = 19'd5;
    localparam logic [QUOT_W-1:0]      Y_MAX         = 17'd65535;

    // Commands from controller to datapath
    typedef struct packed {
        logic take_sample;
        logic load_result;
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic closes;
    } t_status;

    // Clip length with zero read as one
    function automatic logic [SAMPLE_COUNT_BITS-1:0] eff_samples(
        input logic [SAMPLE_COUNT_BITS-1:0] n
    );
        eff_samples = (n == '0) ? SAMPLE_COUNT_BITS'(1) : n;
    endfunction

    // Column count with zero read as one, saturated to the maximum and to N
    function automatic logic [COL_W-1:0] eff_columns(
        input logic [COL_W-1:0]             cols,
        input logic [SAMPLE_COUNT_BITS-1:0] n
    );
        logic [COL_W-1:0]             w;
        logic [SAMPLE_COUNT_BITS-1:0] ne;
        ne = eff_samples(n);
        w  = (cols == '0) ? COL_W'(1) : cols;
        if (w > COL_W'(MAX_COLUMNS)) w = COL_W'(MAX_COLUMNS);
        if (SAMPLE_COUNT_BITS'(w) > ne) w = ne[COL_W-1:0];
        eff_columns = w;
    endfunction

endpackage

`default_nettype wire

// File: rtl/wcmm_ctrl.sv
// Controller of the waveform column min/max unit.
// Sequences sample intake, the scaling pipeline states and result handoff.
// Depends on wcmm_pkg.
`default_nettype none

module wcmm_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    output logic             o_ready,
    output logic             o_valid,
    input  wire              i_ready,
    input  wcmm_pkg::t_status i_status,
    output wcmm_pkg::t_cmd    o_cmd
);
    import wcmm_pkg::*;

    typedef enum logic [5:0] {
        S_RUN = 6'b000001,
        S_MUL = 6'b000010,
        S_DIV = 6'b000100,
        S_EST = 6'b001000,
        S_FIX = 6'b010000,
        S_OUT = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Decode handshakes and commands
    always_comb begin
        o_ready           = (r_state == S_RUN);
        o_valid           = (r_state == S_OUT);
        o_cmd.take_sample = (r_state == S_RUN) && i_valid;
        o_cmd.load_result = (r_state == S_FIX);
    end

    // Advance through scaling once a column closes
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_RUN: begin
                if (i_valid && i_status.closes) n_state = S_MUL;
            end
            S_MUL: n_state = S_DIV;
            S_DIV: n_state = S_EST;
            S_EST: n_state = S_FIX;
            S_FIX: n_state = S_OUT;
            S_OUT: begin
                if (i_ready) n_state = S_RUN;
            end
            default: n_state = S_RUN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RUN;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// File: rtl/wcmm_datapath.sv
// Datapath of the waveform column min/max unit.
// Holds configuration, boundary accumulator, running min/max and line-end scaling.
// Depends on wcmm_pkg.
`default_nettype none

module wcmm_datapath (
    input  wire                                    i_clk,
    input  wire                                    i_rst_n,
    input  wire                                    i_cfg_we,
    input  wire [wcmm_pkg::CFG_INDEX_W-1:0]        i_cfg_index,
    input  wire [wcmm_pkg::CFG_DATA_W-1:0]         i_cfg_data,
    input  wire signed [wcmm_pkg::SAMPLE_W-1:0]    i_sample,
    input  wcmm_pkg::t_cmd                         i_cmd,
    output wcmm_pkg::t_status                      o_status,
    output logic [wcmm_pkg::IDX_W-1:0]             o_column,
    output logic [wcmm_pkg::Y_W-1:0]               o_top_y,
    output logic [wcmm_pkg::Y_W-1:0]               o_bottom_y,
    output logic                                   o_last_column
);
    import wcmm_pkg::*;

    // Configuration registers
    logic [SAMPLE_COUNT_BITS-1:0] r_total,  n_total;
    logic [COL_W-1:0]             r_cols,   n_cols;
    logic [HEIGHT_W-1:0]          r_height, n_height;
    logic                         cfg_hit;

    // Column tracking state
    logic [SAMPLE_COUNT_BITS-1:0] r_acc,    n_acc;
    logic [IDX_W-1:0]             r_idx,    n_idx;
    logic signed [SAMPLE_W-1:0]   r_min,    n_min;
    logic signed [SAMPLE_W-1:0]   r_max,    n_max;

    // Closed column snapshot; lane 0 is the maximum, lane 1 the minimum
    logic signed [SAMPLE_W-1:0]   r_lane_v [2];
    logic [IDX_W-1:0]             r_res_col;
    logic                         r_res_last;

    // Scaling pipeline
    logic [PROD_W-1:0]            r_prod [2];
    logic [Q_W-1:0]               r_q    [2];
    logic [EST_W-1:0]             r_est  [2];
    logic [QUOT_W-1:0]            y_fix  [2];
    logic [Y_W-1:0]               y_out  [2];

    logic [SAMPLE_COUNT_BITS-1:0] cur_n, new_n;
    logic [COL_W-1:0]             cur_w, new_w;
    logic signed [SAMPLE_W-1:0]   s_min, s_max;
    logic                         closes, last;

    // Decode the configuration write
    always_comb begin
        n_total  = r_total;
        n_cols   = r_cols;
        n_height = r_height;
        cfg_hit  = 1'b0;
        if (i_cfg_we) begin
            case (i_cfg_index)
                REG_TOTAL_SAMPLES: begin
                    n_total = i_cfg_data[SAMPLE_COUNT_BITS-1:0];
                    cfg_hit = 1'b1;
                end
                REG_COLUMN_COUNT: begin
                    n_cols  = i_cfg_data[COL_W-1:0];
                    cfg_hit = 1'b1;
                end
                REG_ROW_HEIGHT: begin
                    n_height = i_cfg_data[HEIGHT_W-1:0];
                    cfg_hit  = 1'b1;
                end
                default: cfg_hit = 1'b0;
            endcase
        end
    end

    // Effective clip length and column count, current and after the write
    always_comb begin
        cur_n = eff_samples(r_total);
        cur_w = eff_columns(r_cols, r_total);
        new_n = eff_samples(n_total);
        new_w = eff_columns(n_cols, n_total);
    end

    // Fold the sample into the running extremes and test the column boundary
    always_comb begin
        s_min  = (i_sample < r_min) ? i_sample : r_min;
        s_max  = (i_sample > r_max) ? i_sample : r_max;
        closes = (r_acc < SAMPLE_COUNT_BITS'(cur_w));
        last   = ((COL_W'(r_idx) + COL_W'(1)) >= cur_w);
        o_status.closes = closes;
    end

    // Next column state: rearm on config, else step on each taken sample
    always_comb begin
        n_acc = r_acc;
        n_idx = r_idx;
        n_min = r_min;
        n_max = r_max;
        if (cfg_hit) begin
            n_acc = new_n - SAMPLE_COUNT_BITS'(new_w);
            n_idx = '0;
            n_min = '0;
            n_max = '0;
        end else if (i_cmd.take_sample) begin
            if (!closes) begin
                n_acc = r_acc - SAMPLE_COUNT_BITS'(cur_w);
                n_min = s_min;
                n_max = s_max;
            end else if (last) begin
                n_acc = cur_n - SAMPLE_COUNT_BITS'(cur_w);
                n_idx = '0;
                n_min = '0;
                n_max = '0;
            end else begin
                n_acc = r_acc + cur_n - SAMPLE_COUNT_BITS'(cur_w);
                n_idx = r_idx + IDX_W'(1);
                n_min = '0;
                n_max = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total  <= SAMPLE_COUNT_BITS'(1);
            r_cols   <= COL_W'(1);
            r_height <= HEIGHT_W'(1);
            r_acc    <= '0;
            r_idx    <= '0;
            r_min    <= '0;
            r_max    <= '0;
        end else begin
            r_total  <= n_total;
            r_cols   <= n_cols;
            r_height <= n_height;
            r_acc    <= n_acc;
            r_idx    <= n_idx;
            r_min    <= n_min;
            r_max    <= n_max;
        end
    end

    // Capture the closed column
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_sample && closes) begin
            r_lane_v[0] <= s_max;
            r_lane_v[1] <= s_min;
            r_res_col   <= r_idx;
            r_res_last  <= last;
        end
    end

    // Scale both extremes: multiply, round and shift, then reciprocal divide by five
    always_ff @(posedge i_clk) begin
        for (int l = 0; l < 2; l++) begin
            r_prod[l] <= PROD_W'(r_height *
                         DIFF_W'(CENTER_OFFSET - (DIFF_W + 1)'(r_lane_v[l])));
            r_q[l]    <= Q_W'((r_prod[l] + ROUND_HALF) >> 10);
            r_est[l]  <= EST_W'(r_q[l]) * EST_W'(RECIP_FIVE);
        end
    end

    // Correct the quotient estimate by one where the remainder reaches five
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            logic [QUOT_W-1:0] t;
            logic [Q_W-1:0]    rem;
            t   = r_est[l][EST_W-1:RECIP_SH];
            rem = r_q[l] - (Q_W'(t) << 2) - Q_W'(t);
            y_fix[l] = (rem >= DIVISOR_FIVE) ? t + QUOT_W'(1) : t;
            y_out[l] = (y_fix[l] > Y_MAX) ? Y_MAX[Y_W-1:0] : y_fix[l][Y_W-1:0];
        end
    end

    // Hold the result until taken
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_result) begin
            o_column      <= r_res_col;
            o_top_y       <= y_out[0];
            o_bottom_y    <= y_out[1];
            o_last_column <= r_res_last;
        end
    end

endmodule

`default_nettype wire

// File: rtl/waveform_column_min_max_unit.sv
// Top level of the waveform column min/max unit.
// Joins the controller and the datapath. Depends on wcmm_pkg, wcmm_ctrl, wcmm_datapath.
`default_nettype none

// Splits a stream of signed Q1.15 samples into display columns and reports,
// per closed column, the top and bottom line ends in 1/16-pixel units. A
// sample that does not close a column leaves the input ready, so a clip streams
// at one sample per clock between column ends. A sample that closes a column
// passes through intake and the multiply, round-and-shift, reciprocal-multiply
// and correction stages of the scaling pipeline before the result is shown,
// and the input stays stalled until that result is taken. Any write to a known
// register restarts the clip at column zero and drops a partial column.
module waveform_column_min_max_unit (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_cfg_we,
    input  wire [wcmm_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  wire [wcmm_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  wire                                 i_valid,
    output logic                                o_ready,
    input  wire signed [wcmm_pkg::SAMPLE_W-1:0] i_sample,
    output logic                                o_valid,
    input  wire                                 i_ready,
    output logic [wcmm_pkg::IDX_W-1:0]          o_column,
    output logic [wcmm_pkg::Y_W-1:0]            o_top_y,
    output logic [wcmm_pkg::Y_W-1:0]            o_bottom_y,
    output logic                                o_last_column
);
    import wcmm_pkg::*;

    t_cmd    cmd;
    t_status status;

    // Sequence the transactions
    wcmm_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // Track columns and scale the line ends
    wcmm_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_sample      (i_sample),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_column      (o_column),
        .o_top_y       (o_top_y),
        .o_bottom_y    (o_bottom_y),
        .o_last_column (o_last_column)
    );

endmodule

`default_nettype wire

// File: rtl/wcmm_checker.sv
// Port-level checker for the waveform column min/max unit, with its bind.
// Depends on wcmm_pkg and the top level waveform_column_min_max_unit.
`default_nettype none

module wcmm_checker (
    input wire                                 i_clk,
    input wire                                 i_rst_n,
    input wire                                 i_valid,
    input wire                                 o_ready,
    input wire                                 o_valid,
    input wire                                 i_ready,
    input wire [wcmm_pkg::IDX_W-1:0]           o_column,
    input wire [wcmm_pkg::Y_W-1:0]             o_top_y,
    input wire [wcmm_pkg::Y_W-1:0]             o_bottom_y,
    input wire                                 o_last_column
);
    import wcmm_pkg::*;

    // Hold a stalled result transaction
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_column) && $stable(o_top_y)
            && $stable(o_bottom_y) && $stable(o_last_column))
        else $error("result changed while stalled");

    // Never take a sample while a result waits
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("input ready while result pending");

    // Maximum sits at or above the minimum, so top never lies below bottom
    a_line_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_top_y <= o_bottom_y)
        else $error("top line end below bottom line end");

    // A result only follows the scaling pipeline, never a ready cycle
    a_pipeline_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> !$past(o_ready) && !$past(o_ready, 2))
        else $error("result appeared without scaling latency");

endmodule

bind waveform_column_min_max_unit wcmm_checker u_wcmm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_ready       (o_ready),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_column      (o_column),
    .o_top_y       (o_top_y),
    .o_bottom_y    (o_bottom_y),
    .o_last_column (o_last_column)
);

`default_nettype wire

// File: tb/tb_waveform_column_min_max_unit.sv
// Testbench for waveform_column_min_max_unit: streams samples, predicts every closed
// column and compares it field by field. Depends on wcmm_pkg and the unit's RTL.
module tb_waveform_column_min_max_unit;
    import wcmm_pkg::*;

    // Index that decodes to no register
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;
    localparam int GAP_MAX        = 18;
    localparam int DRAIN_CYCLES   = 16;
    localparam int RANDOM_SAMPLES = 1630;
    localparam int CYCLE_LIMIT    = 600000;

    typedef struct packed {
        logic [IDX_W-1:0] column;
        logic [Y_W-1:0]   top_y;
        logic [Y_W-1:0]   bottom_y;
        logic             last_column;
    } column_result_t;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       i_cfg_we;
    logic [CFG_INDEX_W-1:0]     i_cfg_index;
    logic [CFG_DATA_W-1:0]      i_cfg_data;
    logic                       i_valid;
    logic                       o_ready;
    logic signed [SAMPLE_W-1:0] i_sample;
    logic                       o_valid;
    logic                       i_ready;
    logic [IDX_W-1:0]           o_column;
    logic [Y_W-1:0]             o_top_y;
    logic [Y_W-1:0]             o_bottom_y;
    logic                       o_last_column;

    // Predicted register contents and clip state
    logic [23:0]    clip_samples_reg;
    logic [12:0]    column_count_reg;
    logic [11:0]    row_height_reg;
    longint         boundary_acc;
    int unsigned    column_idx;
    int             col_min;
    int             col_max;
    column_result_t expected_columns[$];

    // Run bookkeeping
    int  error_count   = 0;
    int  samples_sent  = 0;
    int  columns_seen  = 0;
    int  last_columns  = 0;
    int  reg_writes    = 0;
    int  cycle_count   = 0;
    bit  src_steady    = 1'b0;
    bit  sink_steady   = 1'b0;

    waveform_column_min_max_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_sample      (i_sample),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_column      (o_column),
        .o_top_y       (o_top_y),
        .o_bottom_y    (o_bottom_y),
        .o_last_column (o_last_column)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic report(input string msg);
        $display("[%0d] MISMATCH %s", cycle_count, msg);
        error_count++;
    endtask

    // Clip length with zero read as one
    function automatic longint clip_length();
        return (clip_samples_reg == '0) ? 1 : longint'(clip_samples_reg);
    endfunction

    // Column count after zero fixup and saturation
    function automatic longint clip_columns();
        longint w;
        w = (column_count_reg == '0) ? 1 : longint'(column_count_reg);
        if (w > MAX_COLUMNS) w = MAX_COLUMNS;
        if (w > clip_length()) w = clip_length();
        return w;
    endfunction

    function automatic void restart_clip();
        boundary_acc = clip_length() - clip_columns();
        column_idx   = 0;
        col_min      = 0;
        col_max      = 0;
    endfunction

    function automatic void apply_write(input logic [CFG_INDEX_W-1:0] index,
                                        input logic [CFG_DATA_W-1:0] data);
        case (index)
            REG_TOTAL_SAMPLES: clip_samples_reg = data[23:0];
            REG_COLUMN_COUNT:  column_count_reg = data[12:0];
            REG_ROW_HEIGHT:    row_height_reg   = data[11:0];
            default:           return;
        endcase
        restart_clip();
    endfunction

    // Line end in 1/16 pixel: round(16 * (h/2 - v*h*0.4/32768)), halves up
    function automatic logic [Y_W-1:0] line_end(input int v);
        longint num;
        longint y;
        num = longint'(row_height_reg) * longint'(40960 - v);
        y   = (num + 2560) / 5120;
        if (y > 65535) y = 65535;
        return y[Y_W-1:0];
    endfunction

    // Fold one sample into the column and queue the result if it closes it
    function automatic void predict_column(input logic signed [SAMPLE_W-1:0] s);
        int             v;
        longint         w;
        column_result_t res;
        v = s;
        w = clip_columns();
        if (v < col_min) col_min = v;
        if (v > col_max) col_max = v;
        if (boundary_acc >= w) begin
            boundary_acc -= w;
            return;
        end
        res.column      = column_idx[IDX_W-1:0];
        res.top_y       = line_end(col_max);
        res.bottom_y    = line_end(col_min);
        res.last_column = (longint'(column_idx) + 1 >= w);
        expected_columns.push_back(res);
        if (res.last_column) begin
            restart_clip();
        end else begin
            column_idx++;
            boundary_acc = boundary_acc + clip_length() - w;
            col_min      = 0;
            col_max      = 0;
        end
    endfunction

    // Offer one sample and hold it until the transaction completes
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] value);
        int gap;
        gap = src_steady ? 0 : $urandom_range(0, GAP_MAX);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_sample <= value;
        do @(posedge i_clk); while (!o_ready);
        predict_column(value);
        samples_sent++;
    endtask

    // Write a register once the unit has drained
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        i_valid <= 1'b0;
        while (expected_columns.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        apply_write(index, data);
        reg_writes++;
    endtask

    task automatic configure_clip(input logic [23:0] samples, input logic [23:0] columns,
                                  input logic [23:0] height);
        write_reg(REG_TOTAL_SAMPLES, samples);
        write_reg(REG_COLUMN_COUNT, columns);
        write_reg(REG_ROW_HEIGHT, height);
    endtask

    function automatic logic [SAMPLE_W-1:0] draw_sample();
        case ($urandom_range(0, 9))
            0:       return ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000;
            1, 2:    return 16'($urandom_range(0, 255) - 128);
            default: return 16'($urandom);
        endcase
    endfunction

    // Output side: stall at random, then check each transaction
    initial begin
        column_result_t want;
        int             gap;
        i_ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            gap = sink_steady ? 0 : $urandom_range(0, GAP_MAX);
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            columns_seen++;
            if (o_last_column) last_columns++;
            if (expected_columns.size() == 0) begin
                report($sformatf("unexpected column %0d", o_column));
            end else begin
                want = expected_columns.pop_front();
                if (o_column !== want.column)
                    report($sformatf("column got %0d expected %0d", o_column, want.column));
                if (o_top_y !== want.top_y)
                    report($sformatf("column %0d top_y got %0d expected %0d",
                                     want.column, o_top_y, want.top_y));
                if (o_bottom_y !== want.bottom_y)
                    report($sformatf("column %0d bottom_y got %0d expected %0d",
                                     want.column, o_bottom_y, want.bottom_y));
                if (o_last_column !== want.last_column)
                    report($sformatf("column %0d last_column got %0b expected %0b",
                                     want.column, o_last_column, want.last_column));
            end
        end
    end

    // Single-sample clips left by reset, extreme samples
    task automatic test_reset_values();
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
    endtask

    task automatic test_sample_extremes();
        configure_clip(24'd4, 24'd2, 24'd4095);
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        send_sample(16'sh0000);
        send_sample(16'shFFFF);
    endtask

    // Zero length, zero columns and zero height
    task automatic test_zero_settings();
        configure_clip(24'd0, 24'd0, 24'd0);
        send_sample(16'sh4000);
        send_sample(16'shC000);
    endtask

    // Columns of unequal length
    task automatic test_uneven_columns();
        configure_clip(24'd7, 24'd3, 24'd100);
        repeat (7) send_sample(draw_sample());
    endtask

    // Column count above the maximum and above the clip length; unknown register
    task automatic test_register_extremes();
        configure_clip(24'd3, 24'hFFFFFF, 24'd1);
        repeat (3) send_sample(draw_sample());
        configure_clip(24'hFFFFFF, 24'd8191, 24'd4095);
        repeat (4) send_sample(draw_sample());
        write_reg(REG_SPARE, 24'hA5A5A5);
        repeat (2) send_sample(draw_sample());
    endtask

    // Random clip settings with full and partial clips
    task automatic test_random_clips();
        logic [23:0] samples;
        logic [23:0] columns;
        logic [23:0] height;
        longint      count;
        while (samples_sent < RANDOM_SAMPLES) begin
            samples = ($urandom_range(0, 19) == 0) ? 24'd0 : 24'($urandom_range(1, 70));
            case ($urandom_range(0, 7))
                0:       columns = 24'd0;
                1:       columns = {11'($urandom), 13'd8191};
                2:       columns = samples + 24'($urandom_range(0, 10));
                default: columns = 24'($urandom_range(1, (samples > 1) ? samples : 1));
            endcase
            columns[23:13] = 11'($urandom);
            case ($urandom_range(0, 5))
                0:       height = 24'd0;
                1:       height = 24'd4095;
                2:       height = 24'd1;
                default: height = 24'($urandom_range(1, 4095));
            endcase
            height[23:12] = 12'($urandom);
            configure_clip(samples, columns, height);
            if ($urandom_range(0, 4) == 0) write_reg(REG_SPARE, 24'($urandom));
            src_steady  = ($urandom_range(0, 3) == 0);
            sink_steady = ($urandom_range(0, 3) == 0);
            count = clip_length() * $urandom_range(1, 2);
            if ($urandom_range(0, 3) == 0) count += $urandom_range(0, clip_length());
            repeat (count) send_sample(draw_sample());
        end
        src_steady  = 1'b0;
        sink_steady = 1'b0;
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        i_valid     <= 1'b0;
        i_sample    <= '0;
        clip_samples_reg = 24'd1;
        column_count_reg = 13'd1;
        row_height_reg   = 12'd1;
        restart_clip();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_values();
        test_sample_extremes();
        test_zero_settings();
        test_uneven_columns();
        test_register_extremes();
        test_random_clips();

        // Drain the outstanding columns
        i_valid <= 1'b0;
        while (expected_columns.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Streamed %0d samples over %0d register writes", samples_sent, reg_writes);
        $display("Checked %0d closed columns, %0d of them clip ends", columns_seen,
                 last_columns);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
